// ----- rtl/json_string_unescape_utf8_assert.svh -----
// Assertion macros for the JSON string unescaper; empty when synthesized.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTHESIS
`define JSU8_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define JSU8_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define JSU8_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define JSU8_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- rtl/jsu8_pkg.sv -----
// Types, constants and decode functions of the JSON string unescaper.
package jsu8_pkg;

    localparam int RES_DEPTH = 6;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
    localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_END = 16'hE000;
    localparam logic [20:0] PLANE1_BASE  = 21'h10000;
    localparam logic [20:0] TWO_BYTE_END = 21'h800;
    localparam logic [20:0] ONE_BYTE_END = 21'h80;
    localparam logic [7:0]  LEAD2        = 8'hC0;
    localparam logic [7:0]  LEAD3        = 8'hE0;
    localparam logic [7:0]  LEAD4        = 8'hF0;
    localparam logic [7:0]  CONT         = 8'h80;
    localparam logic [7:0]  CONT_MASK    = 8'h3F;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_FF   = 8'h0C;
    localparam logic [7:0] BYTE_CR   = 8'h0D;

    typedef enum logic [2:0] {
        M_PLAIN   = 3'd0,
        M_ESC     = 3'd1,
        M_HEX1    = 3'd2,
        M_HELD    = 3'd3,
        M_HELD_BS = 3'd4,
        M_HEX2    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_END   = 2'd1,
        K_ERROR = 2'd2
    } t_kind;

    // A short run of result bytes that share one kind.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
        t_kind           kind;
    } t_seq;

    function automatic t_seq f_seq_none();
        t_seq s;
        s.bytes = '0;
        s.len   = 3'd0;
        s.kind  = K_DATA;
        return s;
    endfunction

    function automatic t_seq f_seq_single(input logic [7:0] b, input t_kind k);
        t_seq s;
        s          = f_seq_none();
        s.bytes[0] = b;
        s.len      = 3'd1;
        s.kind     = k;
        return s;
    endfunction

    function automatic t_seq f_utf8_encode(input logic [20:0] cp);
        t_seq s;
        s = f_seq_none();
        if (cp < ONE_BYTE_END) begin
            s.len      = 3'd1;
            s.bytes[0] = cp[7:0];
        end else if (cp < TWO_BYTE_END) begin
            s.len      = 3'd2;
            s.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            s.bytes[1] = CONT | ({2'b00, cp[5:0]} & CONT_MASK);
        end else if (cp < PLANE1_BASE) begin
            s.len      = 3'd3;
            s.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            s.bytes[1] = CONT | ({2'b00, cp[11:6]} & CONT_MASK);
            s.bytes[2] = CONT | ({2'b00, cp[5:0]} & CONT_MASK);
        end else begin
            s.len      = 3'd4;
            s.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            s.bytes[1] = CONT | ({2'b00, cp[17:12]} & CONT_MASK);
            s.bytes[2] = CONT | ({2'b00, cp[11:6]} & CONT_MASK);
            s.bytes[3] = CONT | ({2'b00, cp[5:0]} & CONT_MASK);
        end
        return s;
    endfunction

    // Returns a valid flag above the four-bit digit value.
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'b00000;
        case (c) inside
            [CH_0:CH_9]: begin
                d = c - CH_0;
                r = {1'b1, d[3:0]};
            end
            [CH_LA:CH_LF]: begin
                d = c - CH_LA + 8'd10;
                r = {1'b1, d[3:0]};
            end
            [CH_UA:CH_UF]: begin
                d = c - CH_UA + 8'd10;
                r = {1'b1, d[3:0]};
            end
            default: begin
                r = 5'b00000;
            end
        endcase
        return r;
    endfunction

    function automatic t_seq f_plain(input logic [7:0] c);
        t_seq s;
        case (c)
            CH_QUOTE:  s = f_seq_single(8'h00, K_END);
            CH_NUL:    s = f_seq_single(8'h00, K_ERROR);
            CH_BSLASH: s = f_seq_none();
            default:   s = f_seq_single(c, K_DATA);
        endcase
        return s;
    endfunction

    function automatic t_seq f_escape(input logic [7:0] c);
        t_seq s;
        case (c)
            CH_N:    s = f_seq_single(BYTE_LF, K_DATA);
            CH_T:    s = f_seq_single(BYTE_TAB, K_DATA);
            CH_R:    s = f_seq_single(BYTE_CR, K_DATA);
            CH_B:    s = f_seq_single(BYTE_BS, K_DATA);
            CH_F:    s = f_seq_single(BYTE_FF, K_DATA);
            CH_U:    s = f_seq_none();
            CH_NUL:  s = f_seq_single(8'h00, K_ERROR);
            default: s = f_seq_single(c, K_DATA);
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/json_string_unescape_utf8.sv -----
// JSON string body unescaper that turns escapes and \u codes into UTF-8 bytes.
// An accepted byte is decoded in the cycle it is taken; its results are loaded into the
// result queue and then move one by one through the output register to the output.
// One byte is taken per cycle while each byte yields at most one result and the output is
// not stalled; after a byte with more results the next is taken as its last result moves out.
// Synchronous active-low reset returns the decoder to plain character mode, empty.
`include "json_string_unescape_utf8_assert.svh"

module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_kind,
    output logic       o_last
);
    import jsu8_pkg::*;

    t_mode          r_mode, n_mode;
    logic [1:0]     r_digit_count, n_digit_count;
    logic [15:0]    r_code_accum, n_code_accum;
    logic [15:0]    r_held_high, n_held_high;

    logic [7:0]     r_buf_byte [RES_DEPTH];
    t_kind          r_buf_kind [RES_DEPTH];
    logic [RES_CNT_W-1:0] r_buf_cnt;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    t_kind          r_out_kind;
    logic           r_out_last;

    logic [4:0]     hex;
    logic           hex_ok;
    logic [15:0]    accum_next;
    logic           code_done;
    logic           acc_is_high;
    logic           acc_is_low;
    logic [20:0]    pair_cp;
    logic           restart_hit;

    t_seq           seq;
    t_seq           held_seq;
    logic           pre;
    logic [7:0]     res_byte [RES_DEPTH];
    t_kind          res_kind [RES_DEPTH];
    logic [RES_CNT_W-1:0] res_cnt;

    logic           accept;
    logic           move;

    assign hex         = f_hex(i_ch);
    assign hex_ok      = hex[4];
    assign accum_next  = {r_code_accum[11:0], hex[3:0]};
    assign code_done   = (r_digit_count == 2'd3);
    assign acc_is_high = (accum_next >= SURR_HIGH_LO) && (accum_next < SURR_LOW_LO);
    assign acc_is_low  = (accum_next >= SURR_LOW_LO) && (accum_next < SURR_LOW_END);
    assign pair_cp     = PLANE1_BASE + {1'b0, r_held_high[9:0], accum_next[9:0]};
    assign held_seq    = f_utf8_encode({5'b00000, r_held_high});

    always_comb begin
        n_mode        = r_mode;
        n_digit_count = r_digit_count;
        n_code_accum  = r_code_accum;
        n_held_high   = r_held_high;
        restart_hit   = 1'b0;
        case (r_mode)
            M_ESC, M_HELD_BS: begin
                if (i_ch == CH_U) begin
                    n_mode        = (r_mode == M_HELD_BS) ? M_HEX2 : M_HEX1;
                    n_digit_count = 2'd0;
                    n_code_accum  = 16'h0000;
                end else if (i_ch == CH_NUL) begin
                    restart_hit = 1'b1;
                end else begin
                    n_mode = M_PLAIN;
                end
            end
            M_HEX1, M_HEX2: begin
                if (!hex_ok) begin
                    restart_hit = 1'b1;
                end else begin
                    n_code_accum = accum_next;
                    if (code_done) begin
                        n_digit_count = 2'd0;
                        if (r_mode == M_HEX2 && acc_is_low) begin
                            n_mode = M_PLAIN;
                        end else if (acc_is_high) begin
                            n_held_high = accum_next;
                            n_mode      = M_HELD;
                        end else begin
                            n_mode = M_PLAIN;
                        end
                    end else begin
                        n_digit_count = r_digit_count + 2'd1;
                    end
                end
            end
            default: begin
                if (r_mode == M_HELD && i_ch == CH_BSLASH) begin
                    n_mode = M_HELD_BS;
                end else if (i_ch == CH_QUOTE || i_ch == CH_NUL) begin
                    restart_hit = 1'b1;
                end else if (i_ch == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else begin
                    n_mode = M_PLAIN;
                end
            end
        endcase
        if (restart_hit) begin
            n_mode        = M_PLAIN;
            n_digit_count = 2'd0;
            n_code_accum  = 16'h0000;
            n_held_high   = 16'h0000;
        end
    end

    always_comb begin
        pre = 1'b0;
        seq = f_seq_none();
        case (r_mode)
            M_ESC: begin
                seq = f_escape(i_ch);
            end
            M_HEX1: begin
                if (!hex_ok) begin
                    seq = f_seq_single(8'h00, K_ERROR);
                end else if (code_done && !acc_is_high) begin
                    seq = f_utf8_encode({5'b00000, accum_next});
                end
            end
            M_HELD: begin
                if (i_ch != CH_BSLASH) begin
                    pre = 1'b1;
                    seq = f_plain(i_ch);
                end
            end
            M_HELD_BS: begin
                if (i_ch != CH_U) begin
                    pre = 1'b1;
                    seq = f_escape(i_ch);
                end
            end
            M_HEX2: begin
                if (!hex_ok) begin
                    seq = f_seq_single(8'h00, K_ERROR);
                end else if (code_done) begin
                    if (acc_is_low) begin
                        seq = f_utf8_encode(pair_cp);
                    end else begin
                        pre = 1'b1;
                        if (!acc_is_high) begin
                            seq = f_utf8_encode({5'b00000, accum_next});
                        end
                    end
                end
            end
            default: begin
                seq = f_plain(i_ch);
            end
        endcase

        // A pending high surrogate always encodes to three bytes ahead of the rest.
        if (pre) begin
            res_byte[0] = held_seq.bytes[0];
            res_byte[1] = held_seq.bytes[1];
            res_byte[2] = held_seq.bytes[2];
            res_byte[3] = seq.bytes[0];
            res_byte[4] = seq.bytes[1];
            res_byte[5] = seq.bytes[2];
            res_kind[0] = K_DATA;
            res_kind[1] = K_DATA;
            res_kind[2] = K_DATA;
            res_kind[3] = seq.kind;
            res_kind[4] = seq.kind;
            res_kind[5] = seq.kind;
            res_cnt     = RES_CNT_W'(3) + RES_CNT_W'(seq.len);
        end else begin
            res_byte[0] = seq.bytes[0];
            res_byte[1] = seq.bytes[1];
            res_byte[2] = seq.bytes[2];
            res_byte[3] = seq.bytes[3];
            res_byte[4] = 8'h00;
            res_byte[5] = 8'h00;
            res_kind[0] = seq.kind;
            res_kind[1] = seq.kind;
            res_kind[2] = seq.kind;
            res_kind[3] = seq.kind;
            res_kind[4] = seq.kind;
            res_kind[5] = seq.kind;
            res_cnt     = RES_CNT_W'(seq.len);
        end
    end

    assign move    = (r_buf_cnt != '0) && (!r_out_valid || !i_stall);
    assign o_stall = (r_buf_cnt != '0) && !((r_buf_cnt == RES_CNT_W'(1)) && move);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= M_PLAIN;
            r_digit_count <= 2'd0;
            r_code_accum  <= 16'h0000;
            r_held_high   <= 16'h0000;
            r_buf_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_mode        <= n_mode;
                r_digit_count <= n_digit_count;
                r_code_accum  <= n_code_accum;
                r_held_high   <= n_held_high;
                r_buf_cnt     <= res_cnt;
            end else if (move) begin
                r_buf_cnt <= r_buf_cnt - RES_CNT_W'(1);
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < RES_DEPTH; i++) begin
                r_buf_byte[i] <= res_byte[i];
                r_buf_kind[i] <= res_kind[i];
            end
        end else if (move) begin
            for (int i = 0; i < RES_DEPTH - 1; i++) begin
                r_buf_byte[i] <= r_buf_byte[i+1];
                r_buf_kind[i] <= r_buf_kind[i+1];
            end
        end
        if (move) begin
            r_out_byte <= r_buf_byte[0];
            r_out_kind <= r_buf_kind[0];
            r_out_last <= (r_buf_cnt == RES_CNT_W'(1));
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_kind     = r_out_kind;
    assign o_last     = r_out_last;

    `JSU8_ASSERT_NEVER(a_buf_cnt_range, i_clk, i_rst_n, r_buf_cnt > RES_CNT_W'(RES_DEPTH))
    `JSU8_ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, accept && r_buf_cnt > RES_CNT_W'(1))
    `JSU8_ASSERT_IMPLY(a_ctrl_alone, i_clk, i_rst_n, r_buf_cnt != '0 && r_buf_kind[0] != K_DATA, r_buf_cnt == RES_CNT_W'(1) && r_mode == M_PLAIN && r_digit_count == 2'd0)
    `JSU8_ASSERT_IMPLY(a_held_surrogate, i_clk, i_rst_n, r_mode == M_HELD || r_mode == M_HELD_BS || r_mode == M_HEX2, r_held_high[15:10] == 6'b110110)
    `JSU8_ASSERT_IMPLY(a_ctrl_last, i_clk, i_rst_n, r_out_valid && r_out_kind != K_DATA, r_out_last && r_out_byte == 8'h00)

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu8_pkg::*;

    localparam int MAX_RESULTS = 6;
    localparam int PAUSE_MARK  = -1;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_res;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_ch;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic       o_last;

    json_string_unescape_utf8 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ch       (i_ch),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    int    feed_q[$];
    t_res  decoded_q[$];
    t_res  step_q[$];
    int    n_items;
    int    n_in;
    int    n_err;
    int    cycles;
    int    dropped;
    logic  in_taken;
    logic  rx_hold;
    wire   calm = (n_in >= 180) && (n_in < 260);

    t_mode       dec_mode;
    logic [1:0]  dec_cnt;
    logic [15:0] dec_acc;
    logic [15:0] dec_high;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    task automatic put(input logic [7:0] b, input t_kind k);
        t_res r;
        r.data = b;
        r.kind = k;
        r.last = 1'b0;
        if (step_q.size() < MAX_RESULTS) step_q.push_back(r);
    endtask

    task automatic put_code_point(input logic [20:0] cp);
        if (cp < ONE_BYTE_END) begin
            put(cp[7:0], K_DATA);
        end else if (cp < TWO_BYTE_END) begin
            put(LEAD2 | {3'b000, cp[10:6]}, K_DATA);
            put(CONT | {2'b00, cp[5:0]}, K_DATA);
        end else if (cp < PLANE1_BASE) begin
            put(LEAD3 | {4'b0000, cp[15:12]}, K_DATA);
            put(CONT | {2'b00, cp[11:6]}, K_DATA);
            put(CONT | {2'b00, cp[5:0]}, K_DATA);
        end else begin
            put(LEAD4 | {5'b00000, cp[20:18]}, K_DATA);
            put(CONT | {2'b00, cp[17:12]}, K_DATA);
            put(CONT | {2'b00, cp[11:6]}, K_DATA);
            put(CONT | {2'b00, cp[5:0]}, K_DATA);
        end
    endtask

    task automatic restart_dec();
        dec_mode = M_PLAIN;
        dec_cnt  = 2'd0;
        dec_acc  = 16'h0000;
        dec_high = 16'h0000;
    endtask

    task automatic fail_dec();
        put(8'h00, K_ERROR);
        restart_dec();
    endtask

    task automatic plain_dec(input logic [7:0] c);
        dec_mode = M_PLAIN;
        if (c == CH_QUOTE) begin
            put(8'h00, K_END);
            restart_dec();
        end else if (c == CH_NUL) begin
            fail_dec();
        end else if (c == CH_BSLASH) begin
            dec_mode = M_ESC;
        end else begin
            put(c, K_DATA);
        end
    endtask

    task automatic escape_dec(input logic [7:0] c);
        dec_mode = M_PLAIN;
        case (c)
            CH_N: put(BYTE_LF, K_DATA);
            CH_T: put(BYTE_TAB, K_DATA);
            CH_R: put(BYTE_CR, K_DATA);
            CH_B: put(BYTE_BS, K_DATA);
            CH_F: put(BYTE_FF, K_DATA);
            CH_U: begin
                dec_mode = M_HEX1;
                dec_cnt  = 2'd0;
                dec_acc  = 16'h0000;
            end
            CH_NUL: fail_dec();
            default: put(c, K_DATA);
        endcase
    endtask

    task automatic first_code(input logic [15:0] cp);
        if (cp >= SURR_HIGH_LO && cp < SURR_LOW_LO) begin
            dec_high = cp;
            dec_mode = M_HELD;
        end else begin
            put_code_point({5'b00000, cp});
            dec_mode = M_PLAIN;
        end
    endtask

    function automatic logic add_digit(input int v);
        dec_acc = {dec_acc[11:0], v[3:0]};
        if (dec_cnt == 2'd3) begin
            dec_cnt = 2'd0;
            return 1'b1;
        end
        dec_cnt = dec_cnt + 2'd1;
        return 1'b0;
    endfunction

    task automatic unescape_byte(input logic [7:0] c);
        int          v;
        logic [15:0] lo;
        logic [20:0] hi_off;
        logic [20:0] lo_off;
        t_res        r;
        step_q.delete();
        case (dec_mode)
            M_ESC: escape_dec(c);
            M_HEX1: begin
                v = hex_digit(c);
                if (v < 0) fail_dec();
                else if (add_digit(v)) first_code(dec_acc);
            end
            M_HELD: begin
                if (c == CH_BSLASH) begin
                    dec_mode = M_HELD_BS;
                end else begin
                    put_code_point({5'b00000, dec_high});
                    plain_dec(c);
                end
            end
            M_HELD_BS: begin
                if (c == CH_U) begin
                    dec_mode = M_HEX2;
                    dec_cnt  = 2'd0;
                    dec_acc  = 16'h0000;
                end else begin
                    put_code_point({5'b00000, dec_high});
                    escape_dec(c);
                end
            end
            M_HEX2: begin
                v = hex_digit(c);
                if (v < 0) begin
                    fail_dec();
                end else if (add_digit(v)) begin
                    lo = dec_acc;
                    if (lo >= SURR_LOW_LO && lo < SURR_LOW_END) begin
                        hi_off = {5'b00000, dec_high - SURR_HIGH_LO};
                        lo_off = {5'b00000, lo - SURR_LOW_LO};
                        put_code_point(PLANE1_BASE + (hi_off << 10) + lo_off);
                        dec_mode = M_PLAIN;
                    end else begin
                        put_code_point({5'b00000, dec_high});
                        first_code(lo);
                    end
                end
            end
            default: plain_dec(c);
        endcase
        for (int i = 0; i < step_q.size(); i++) begin
            r = step_q[i];
            r.last = (i == step_q.size() - 1);
            decoded_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what);
        n_err++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic push_byte(input logic [7:0] c);
        feed_q.push_back(int'(c));
        n_items++;
    endtask

    task automatic push_hex4(input logic [15:0] v);
        logic [3:0] nib;
        logic [7:0] base;
        for (int i = 3; i >= 0; i--) begin
            nib  = v[i*4 +: 4];
            base = ($urandom_range(1) == 1) ? CH_UA : CH_LA;
            if (nib < 4'd10) push_byte(CH_0 + {4'b0000, nib});
            else push_byte(base + {4'b0000, nib} - 8'd10);
        end
    endtask

    task automatic push_u(input logic [15:0] v);
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        push_hex4(v);
    endtask

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (hex_digit(c) >= 0) c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic push_bad_u();
        int good;
        good = $urandom_range(3);
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        for (int i = 0; i < good; i++) push_byte(CH_0 + 8'($urandom_range(9)));
        push_byte(non_hex());
    endtask

    function automatic logic [15:0] rand_high();
        return SURR_HIGH_LO + 16'($urandom_range(16'h3FF));
    endfunction

    function automatic logic [15:0] rand_low();
        return SURR_LOW_LO + 16'($urandom_range(16'h3FF));
    endfunction

    task automatic push_token();
        int         sel;
        logic [7:0] c;
        sel = $urandom_range(99);
        if (sel < 28) begin
            c = 8'($urandom_range(1, 255));
            while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(1, 255));
            push_byte(c);
        end else if (sel < 40) begin
            push_byte(CH_BSLASH);
            case ($urandom_range(8))
                0: push_byte(CH_N);
                1: push_byte(CH_T);
                2: push_byte(CH_R);
                3: push_byte(CH_B);
                4: push_byte(CH_F);
                5: push_byte(CH_QUOTE);
                6: push_byte(CH_BSLASH);
                default: push_byte(8'($urandom_range(255)));
            endcase
        end else if (sel < 52) begin
            case ($urandom_range(2))
                0: push_u(16'($urandom_range(16'h7F)));
                1: push_u(16'($urandom_range(16'h80, 16'h7FF)));
                default: push_u(16'($urandom_range(16'h800, 16'hFFFF)));
            endcase
        end else if (sel < 64) begin
            push_u(rand_high());
            push_u(rand_low());
        end else if (sel < 69) begin
            push_u(rand_high());
        end else if (sel < 73) begin
            push_u(rand_low());
        end else if (sel < 78) begin
            push_byte(CH_QUOTE);
        end else if (sel < 81) begin
            push_bad_u();
        end else if (sel < 84) begin
            push_u(rand_high());
            push_bad_u();
        end else if (sel < 88) begin
            push_u(rand_high());
            push_byte(CH_BSLASH);
            push_byte(8'($urandom_range(255)));
        end else begin
            push_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        rx_hold = 1'b0;
        while (n_in < 140) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (feed_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (feed_q[0] == PAUSE_MARK) begin
                i_valid <= 1'b0;
                if (decoded_q.size() == 0) dropped = feed_q.pop_front();
            end else if (!calm && $urandom_range(99) < 15) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_ch    <= 8'(feed_q.pop_front());
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 15);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                unescape_byte(i_ch);
                n_in <= n_in + 1;
            end
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %h kind %0d last %b",
                                              o_out_byte, o_kind, o_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  o_out_byte, want.data));
                    if (o_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", o_kind, want.kind));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                end
            end
        end
    end

    initial begin
        int target;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_ch     = 8'h00;
        i_stall  = 1'b0;
        in_taken = 1'b0;
        n_items  = 0;
        n_in     = 0;
        n_err    = 0;
        restart_dec();

        // Plain bytes at the extremes, then end and error.
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h7F);
        push_byte(CH_QUOTE);
        push_byte(CH_NUL);
        // Short escapes, a literal escape and an escaped NUL.
        push_byte(CH_BSLASH); push_byte(CH_N);
        push_byte(CH_BSLASH); push_byte(CH_T);
        push_byte(CH_BSLASH); push_byte(CH_R);
        push_byte(CH_BSLASH); push_byte(CH_B);
        push_byte(CH_BSLASH); push_byte(CH_F);
        push_byte(CH_BSLASH); push_byte(8'h2F);
        push_byte(CH_BSLASH); push_byte(CH_NUL);
        // A zero code, the largest pair, and a high surrogate replaced by a new one.
        push_u(16'h0000);
        push_u(16'hDBFF); push_u(16'hDFFF);
        push_u(16'hD800); push_u(16'hD83D); push_u(16'hDE00);
        // Lone high surrogates before a plain byte and before a short escape.
        push_u(16'hD800); push_byte(8'h78);
        push_u(16'hDBFF); push_byte(CH_BSLASH); push_byte(CH_N);
        // High surrogate then an ordinary code, and a lone low surrogate.
        push_u(16'hD801); push_u(16'h00E9);
        push_u(16'hDC00);
        // Bad hex digits, with and without a held high surrogate.
        push_u(16'hD800); push_byte(CH_BSLASH); push_byte(CH_U); push_byte(8'h47);
        push_byte(CH_BSLASH); push_byte(CH_U); push_byte(8'hFF);
        feed_q.push_back(PAUSE_MARK);

        target = n_items + 125;
        while (n_items < target) push_token();
        feed_q.push_back(PAUSE_MARK);
        target = n_items + 125;
        while (n_items < target) push_token();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_valid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/jsu8_pkg.sv
rtl/json_string_unescape_utf8.sv
tb/tb.sv
